// ----- rtl/core/pbb_pkg.sv -----
// Package for the price box breakout tracker.
// Holds default widths, the confirmation register reset value and counter helpers.
// No dependencies.
package pbb_pkg;

  localparam int unsigned PRICE_BITS_DEF = 32;
  localparam int unsigned CONFIRM_BITS   = 4;
  localparam int unsigned COUNT_BITS     = 8;

  localparam logic [CONFIRM_BITS-1:0] CONFIRM_RESET = CONFIRM_BITS'(4);
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX     = '1;
  localparam logic [COUNT_BITS-1:0]   COUNT_ONE     = COUNT_BITS'(1);

  typedef logic [CONFIRM_BITS-1:0] confirm_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  function automatic count_t count_up(input count_t c);
    count_t r;
    r = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_ONE;
    return r;
  endfunction

  function automatic logic count_hit(input count_t c, input confirm_t n);
    logic r;
    r = (c == {{(COUNT_BITS-CONFIRM_BITS){1'b0}}, n});
    return r;
  endfunction

endpackage

// ----- rtl/core/pbb_if.sv -----
// Channel interfaces of the price box breakout tracker: bar input, result output
// and the confirmation register write channel.
// Depends on pbb_pkg.
interface pbb_bar_if #(
  parameter int unsigned PRICE_BITS = pbb_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] open_price;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, open_price, high_price, low_price, close_price,
                  input ready);
  modport sink   (input valid, open_price, high_price, low_price, close_price,
                  output ready);
endinterface

interface pbb_result_if #(
  parameter int unsigned PRICE_BITS = pbb_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  buy_now;
  logic                  exit_now;
  logic                  stop_moved;
  logic                  done_latched;
  logic [PRICE_BITS-1:0] box_top_out;
  logic [PRICE_BITS-1:0] box_bottom_out;
  logic [PRICE_BITS-1:0] stop_out;

  modport source (output valid, buy_now, exit_now, stop_moved, done_latched,
                         box_top_out, box_bottom_out, stop_out,
                  input ready);
  modport sink   (input valid, buy_now, exit_now, stop_moved, done_latched,
                        box_top_out, box_bottom_out, stop_out,
                  output ready);
endinterface

interface pbb_cfg_if;
  logic               valid;
  logic               ready;
  pbb_pkg::confirm_t  confirm_bars;

  modport source (output valid, confirm_bars, input ready);
  modport sink   (input valid, confirm_bars, output ready);
endinterface

// ----- rtl/core/price_box_breakout_tracker.sv -----
// Price box breakout tracker: one price bar in, one signal/level result out.
// Depends on pbb_pkg and the channel interfaces in pbb_if.sv.
//
// Usage:
//   bar_i    - valid/ready channel of price bars (open, high, low, close ticks).
//   result_o - valid/ready channel of results: buy, exit, stop-moved and done
//              flags plus the box top, box bottom and stop level after the bar.
//   cfg_i    - valid/ready write of confirm_bars; always ready, write while idle.
//   A transfer happens at a rising clk_i edge with valid and ready both high.
//   Latency: the result of a bar is valid in the cycle after its transfer.
//   Throughput: one bar per cycle. The box update is one pass of compares and
//   two saturating adds between the state registers and the result register.
//   When the receiver stalls, the result register holds and bar_i.ready drops
//   until the result is taken; a bar is taken in the same cycle the held
//   result leaves.
//   Reset (rst_ni low, asynchronous) clears all box state and done, empties the
//   result register (not its buy/exit/moved bits) and sets confirm_bars to 4.
module price_box_breakout_tracker #(
  parameter int unsigned PRICE_BITS = pbb_pkg::PRICE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pbb_bar_if.sink      bar_i,
  pbb_result_if.source result_o,
  pbb_cfg_if.sink      cfg_i
);
  import pbb_pkg::*;

  typedef logic [PRICE_BITS-1:0] price_t;

  function automatic price_t add_sat(input price_t a, input price_t b);
    logic [PRICE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PRICE_BITS] ? '1 : s[PRICE_BITS-1:0];
  endfunction

  price_t   top_q, top_d, bot_q, bot_d, stop_q, stop_d;
  price_t   height_q, height_d, ghost_q, ghost_d;
  count_t   tcnt_q, tcnt_d, bcnt_q, bcnt_d;
  logic     tconf_q, tconf_d, bconf_q, bconf_d, done_q, done_d;
  confirm_t confirm_q;

  logic     out_valid_q;
  logic     buy_q, buy_d, exit_q, exit_d, moved_q, moved_d;

  logic     take;

  assign bar_i.ready = !out_valid_q || result_o.ready;
  assign take        = bar_i.valid && bar_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    price_t op, hi, lo, cl;
    price_t top1, bot1, stop1, ghost1, bot2, stop2, ghost2, height2;
    count_t tcnt1, bcnt1, bcnt2;
    logic   tconf1, bconf1, bconf2, buy, ex, moved;

    op = bar_i.open_price;
    hi = bar_i.high_price;
    lo = bar_i.low_price;
    cl = bar_i.close_price;
    buy = 1'b0;
    ex = 1'b0;
    moved = 1'b0;

    top1 = top_q;
    bot1 = bot_q;
    stop1 = stop_q;
    ghost1 = ghost_q;
    tcnt1 = tcnt_q;
    bcnt1 = bcnt_q;
    tconf1 = tconf_q;
    bconf1 = bconf_q;
    if (hi <= top_q) begin
      tcnt1 = count_up(tcnt_q);
      if (count_hit(tcnt1, confirm_q)) begin
        tconf1 = 1'b1;
      end
    end else begin
      if (tconf_q && bconf_q && (cl > top_q) && (cl > stop_q)) begin
        buy = 1'b1;
        stop1 = top_q;
        ghost1 = add_sat(top_q, height_q);
        moved = 1'b1;
      end
      top1 = hi;
      bot1 = lo;
      tcnt1 = COUNT_ONE;
      bcnt1 = '0;
      tconf1 = 1'b0;
      bconf1 = 1'b0;
    end

    bot2 = bot1;
    stop2 = stop1;
    ghost2 = ghost1;
    height2 = height_q;
    bcnt2 = bcnt1;
    bconf2 = bconf1;
    done_d = done_q;
    if (bconf1) begin
      if (cl < bot1) begin
        ex = 1'b1;
        done_d = 1'b1;
      end else begin
        bcnt2 = count_up(bcnt1);
        if (({{(COUNT_BITS-CONFIRM_BITS){1'b0}}, confirm_q} < bcnt2) &&
            (cl > stop1) && (op < cl)) begin
          buy = 1'b1;
        end
      end
    end else if (lo >= bot1) begin
      bcnt2 = count_up(bcnt1);
      if (count_hit(bcnt2, confirm_q)) begin
        bconf2 = 1'b1;
        if (bot1 > stop1) begin
          stop2 = bot1;
        end
        height2 = (top1 >= bot1) ? top1 - bot1 : '0;
        ghost2 = top1;
        moved = 1'b1;
      end
    end else begin
      bot2 = lo;
      bcnt2 = COUNT_ONE;
    end

    stop_d = stop2;
    ghost_d = ghost2;
    if (!tconf1 && !bconf2 && (stop2 != '0) && (cl > ghost2)) begin
      stop_d = ghost2;
      ghost_d = add_sat(ghost2, height2);
      moved = 1'b1;
    end

    top_d = top1;
    bot_d = bot2;
    height_d = height2;
    tcnt_d = tcnt1;
    bcnt_d = bcnt2;
    tconf_d = tconf1;
    bconf_d = bconf2;
    buy_d = buy;
    exit_d = ex;
    moved_d = moved;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      bot_q <= '0;
      stop_q <= '0;
      height_q <= '0;
      ghost_q <= '0;
      tcnt_q <= '0;
      bcnt_q <= '0;
      tconf_q <= 1'b0;
      bconf_q <= 1'b0;
      done_q <= 1'b0;
    end else if (take) begin
      top_q <= top_d;
      bot_q <= bot_d;
      stop_q <= stop_d;
      height_q <= height_d;
      ghost_q <= ghost_d;
      tcnt_q <= tcnt_d;
      bcnt_q <= bcnt_d;
      tconf_q <= tconf_d;
      bconf_q <= bconf_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= CONFIRM_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      confirm_q <= cfg_i.confirm_bars;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (bar_i.ready) begin
      out_valid_q <= bar_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buy_q <= buy_d;
      exit_q <= exit_d;
      moved_q <= moved_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.buy_now        = buy_q;
  assign result_o.exit_now       = exit_q;
  assign result_o.stop_moved     = moved_q;
  assign result_o.done_latched   = done_q;
  assign result_o.box_top_out    = top_q;
  assign result_o.box_bottom_out = bot_q;
  assign result_o.stop_out       = stop_q;

endmodule

// ----- rtl/core/pbb_checker.sv -----
// Port-level checks for the price box breakout tracker, bound to its top level.
// Depends on pbb_pkg and price_box_breakout_tracker.
module pbb_checker #(
  parameter int unsigned PRICE_BITS = pbb_pkg::PRICE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  bar_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic                  buy_now_i,
  input logic                  exit_now_i,
  input logic                  done_latched_i,
  input logic [PRICE_BITS-1:0] stop_out_i
);
  import pbb_pkg::*;

  logic stall;
  assign stall = res_valid_i && !res_ready_i;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> ($stable(stop_out_i) && $stable(buy_now_i) && $stable(exit_now_i)))
    else $error("stalled result changed");

  a_stall_blocks_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !bar_ready_i)
    else $error("bar taken while result stalled");

  a_exit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && exit_now_i) |-> done_latched_i)
    else $error("exit without done latched");

  a_buy_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(buy_now_i && exit_now_i))
    else $error("buy and exit on one bar");

endmodule

bind price_box_breakout_tracker pbb_checker #(
  .PRICE_BITS(PRICE_BITS)
) u_pbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .bar_ready_i   (bar_i.ready),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .buy_now_i     (result_o.buy_now),
  .exit_now_i    (result_o.exit_now),
  .done_latched_i(result_o.done_latched),
  .stop_out_i    (result_o.stop_out)
);
